FILE: hdl/jbt_pkg.sv
`default_nettype none

package jbt_pkg;

    localparam int MAX_TOKENS    = 64;
    localparam int MAX_DOC_BYTES = 65536;

    localparam int POS_W  = 17;
    localparam int CNT_W  = 7;
    localparam int KIDS_W = 6;
    localparam int IDX_W  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;

    localparam logic [CNT_W-1:0] NO_TOKEN = 7'h7F;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] PRINT_LO     = 8'd32;
    localparam logic [7:0] PRINT_HI     = 8'd127;

    typedef enum logic [1:0] {
        TK_OBJECT,
        TK_ARRAY,
        TK_STRING,
        TK_PRIM
    } tok_kind_t;

    typedef enum logic [1:0] {
        SM_NORMAL,
        SM_STRING,
        SM_ESCAPE,
        SM_PRIM
    } scan_mode_t;

    typedef enum logic [3:0] {
        CL_OPEN_OBJ,
        CL_OPEN_ARR,
        CL_CLOSE_OBJ,
        CL_CLOSE_ARR,
        CL_QUOTE,
        CL_BACKSLASH,
        CL_SEP,
        CL_PRINT,
        CL_BAD
    } byte_class_t;

    typedef enum logic [1:0] {
        NX_OPEN,
        NX_DISPATCH,
        NX_DONE,
        NX_END
    } alloc_next_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_BUMP_RD,
        S_BUMP_WR,
        S_ALLOC_DONE,
        S_CLOSE_RD,
        S_CLOSE_WR,
        S_END_CHECK,
        S_END_DECIDE,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_RESULT_ONE
    } ctrl_state_t;

    typedef struct packed {
        tok_kind_t          kind;
        logic [POS_W-1:0]   first;
        logic [POS_W-1:0]   last;
        logic [KIDS_W-1:0]  kids;
        logic [CNT_W-1:0]   up;
    } tok_entry_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [IDX_W-1:0]  addr;
        tok_entry_t        wdata;
    } ram_req_t;

endpackage

`default_nettype wire

FILE: hdl/jbt_byte_class.sv
`default_nettype none

module jbt_byte_class (
    input  wire logic [7:0]          data_byte,
    output jbt_pkg::byte_class_t     cls
);

    always_comb
    begin
        unique case (data_byte)
            jbt_pkg::CH_LBRACE:    cls = jbt_pkg::CL_OPEN_OBJ;
            jbt_pkg::CH_LBRACKET:  cls = jbt_pkg::CL_OPEN_ARR;
            jbt_pkg::CH_RBRACE:    cls = jbt_pkg::CL_CLOSE_OBJ;
            jbt_pkg::CH_RBRACKET:  cls = jbt_pkg::CL_CLOSE_ARR;
            jbt_pkg::CH_QUOTE:     cls = jbt_pkg::CL_QUOTE;
            jbt_pkg::CH_BACKSLASH: cls = jbt_pkg::CL_BACKSLASH;
            jbt_pkg::CH_SPACE,
            jbt_pkg::CH_TAB,
            jbt_pkg::CH_CR,
            jbt_pkg::CH_LF,
            jbt_pkg::CH_COMMA,
            jbt_pkg::CH_COLON:     cls = jbt_pkg::CL_SEP;
            default:
            begin
                if (data_byte < jbt_pkg::PRINT_LO || data_byte >= jbt_pkg::PRINT_HI)
                    cls = jbt_pkg::CL_BAD;
                else
                    cls = jbt_pkg::CL_PRINT;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/jbt_token_ram.sv
`default_nettype none

module jbt_token_ram (
    input  wire logic                clk,
    input  wire jbt_pkg::ram_req_t   req,
    output jbt_pkg::tok_entry_t      rdata
);

    jbt_pkg::tok_entry_t mem_reg [jbt_pkg::MAX_TOKENS];
    jbt_pkg::tok_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
                mem_reg[req.addr] <= req.wdata;
            else
                rdata_reg <= mem_reg[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/jbt_ctrl.sv
`default_nettype none

module jbt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          end_of_doc,
    output jbt_pkg::ram_req_t                  ram_req,
    input  wire jbt_pkg::tok_entry_t           ram_rdata,
    output logic                               result_strobe,
    output logic                               is_error,
    output logic                               is_last,
    output logic                               token_valid,
    output logic [1:0]                         token_type,
    output logic [jbt_pkg::POS_W-1:0]          start_pos,
    output logic [jbt_pkg::POS_W-1:0]          end_pos,
    output logic [jbt_pkg::KIDS_W-1:0]         child_count,
    output logic signed [jbt_pkg::CNT_W-1:0]   parent_index,
    output logic [jbt_pkg::CNT_W-1:0]          token_count
);

    localparam int POS_W = jbt_pkg::POS_W;
    localparam int CNT_W = jbt_pkg::CNT_W;
    localparam int IDX_W = jbt_pkg::IDX_W;

    jbt_pkg::ctrl_state_t  state_reg, state_next;
    jbt_pkg::scan_mode_t   scan_reg, scan_next;
    jbt_pkg::tok_kind_t    alloc_kind_reg, alloc_kind_next;
    jbt_pkg::alloc_next_t  alloc_nx_reg, alloc_nx_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      byte_position_reg, byte_position_next;
    logic [POS_W-1:0]      pending_reg, pending_next;
    logic [POS_W-1:0]      alloc_first_reg, alloc_first_next;
    logic [POS_W-1:0]      alloc_last_reg, alloc_last_next;
    logic [CNT_W-1:0]      open_reg, open_next;
    logic [CNT_W-1:0]      tokens_used_reg, tokens_used_next;
    logic [CNT_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                  err_reg, err_next;

    jbt_pkg::byte_class_t  cls;
    jbt_pkg::ctrl_state_t  fin_state;
    jbt_pkg::tok_kind_t    want_kind;
    logic                  is_delim;
    logic                  has_open;
    logic                  table_full;
    logic                  pos_over;
    logic                  emit_last;
    logic                  run_clear;

    jbt_byte_class u_class (
        .data_byte (byte_reg),
        .cls       (cls)
    );

    assign is_delim   = (cls == jbt_pkg::CL_CLOSE_OBJ) || (cls == jbt_pkg::CL_CLOSE_ARR) ||
                        (cls == jbt_pkg::CL_SEP);
    assign has_open   = (open_reg != jbt_pkg::NO_TOKEN);
    assign table_full = (tokens_used_reg >= CNT_W'(jbt_pkg::MAX_TOKENS));
    assign pos_over   = (pos_reg >= POS_W'(jbt_pkg::MAX_DOC_BYTES));
    assign emit_last  = ((emit_idx_reg + CNT_W'(1)) == tokens_used_reg);
    assign fin_state  = last_reg ? jbt_pkg::S_END_CHECK : jbt_pkg::S_IDLE;
    assign want_kind  = (cls == jbt_pkg::CL_CLOSE_OBJ) ? jbt_pkg::TK_OBJECT : jbt_pkg::TK_ARRAY;
    assign busy       = (state_reg != jbt_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jbt_pkg::S_IDLE:
            begin
                if (start)
                    state_next = jbt_pkg::S_DISPATCH;
            end
            jbt_pkg::S_DISPATCH:
            begin
                state_next = fin_state;
                if (!err_reg && !pos_over)
                begin
                    unique case (scan_reg)
                        jbt_pkg::SM_PRIM:
                        begin
                            if (is_delim)
                                state_next = jbt_pkg::S_ALLOC;
                        end
                        jbt_pkg::SM_STRING:
                        begin
                            if (cls == jbt_pkg::CL_QUOTE)
                                state_next = jbt_pkg::S_ALLOC;
                        end
                        jbt_pkg::SM_ESCAPE:
                        begin
                            state_next = fin_state;
                        end
                        jbt_pkg::SM_NORMAL:
                        begin
                            if (cls == jbt_pkg::CL_OPEN_OBJ || cls == jbt_pkg::CL_OPEN_ARR)
                                state_next = jbt_pkg::S_ALLOC;
                            else if ((cls == jbt_pkg::CL_CLOSE_OBJ ||
                                      cls == jbt_pkg::CL_CLOSE_ARR) && has_open)
                                state_next = jbt_pkg::S_CLOSE_RD;
                        end
                    endcase
                end
            end
            jbt_pkg::S_ALLOC:
            begin
                if (table_full)
                    state_next = fin_state;
                else if (has_open)
                    state_next = jbt_pkg::S_BUMP_RD;
                else
                    state_next = jbt_pkg::S_ALLOC_DONE;
            end
            jbt_pkg::S_BUMP_RD:  state_next = jbt_pkg::S_BUMP_WR;
            jbt_pkg::S_BUMP_WR:  state_next = jbt_pkg::S_ALLOC_DONE;
            jbt_pkg::S_ALLOC_DONE:
            begin
                unique case (alloc_nx_reg)
                    jbt_pkg::NX_DISPATCH: state_next = jbt_pkg::S_DISPATCH;
                    jbt_pkg::NX_END:      state_next = jbt_pkg::S_END_CHECK;
                    jbt_pkg::NX_OPEN,
                    jbt_pkg::NX_DONE:     state_next = fin_state;
                endcase
            end
            jbt_pkg::S_CLOSE_RD: state_next = jbt_pkg::S_CLOSE_WR;
            jbt_pkg::S_CLOSE_WR: state_next = fin_state;
            jbt_pkg::S_END_CHECK:
            begin
                if (!err_reg && scan_reg == jbt_pkg::SM_PRIM)
                    state_next = jbt_pkg::S_ALLOC;
                else
                    state_next = jbt_pkg::S_END_DECIDE;
            end
            jbt_pkg::S_END_DECIDE:
            begin
                if (err_reg || tokens_used_reg == '0)
                    state_next = jbt_pkg::S_RESULT_ONE;
                else
                    state_next = jbt_pkg::S_EMIT_RD;
            end
            jbt_pkg::S_EMIT_RD:  state_next = jbt_pkg::S_EMIT_OUT;
            jbt_pkg::S_EMIT_OUT:
            begin
                if (emit_last)
                    state_next = jbt_pkg::S_IDLE;
                else
                    state_next = jbt_pkg::S_EMIT_RD;
            end
            jbt_pkg::S_RESULT_ONE: state_next = jbt_pkg::S_IDLE;
            default:               state_next = jbt_pkg::S_IDLE;
        endcase
    end

    // datapath, memory requests and results
    always_comb
    begin
        scan_next          = scan_reg;
        alloc_kind_next    = alloc_kind_reg;
        alloc_nx_next      = alloc_nx_reg;
        byte_next          = byte_reg;
        last_next          = last_reg;
        pos_next           = pos_reg;
        byte_position_next = byte_position_reg;
        pending_next       = pending_reg;
        alloc_first_next   = alloc_first_reg;
        alloc_last_next    = alloc_last_reg;
        open_next          = open_reg;
        tokens_used_next   = tokens_used_reg;
        emit_idx_next      = emit_idx_reg;
        err_next           = err_reg;
        run_clear          = 1'b0;
        ram_req            = '0;

        result_strobe = 1'b0;
        is_error      = 1'b0;
        is_last       = 1'b0;
        token_valid   = 1'b0;
        token_type    = '0;
        start_pos     = '0;
        end_pos       = '0;
        child_count   = '0;
        parent_index  = '0;
        token_count   = '0;

        unique case (state_reg)
            jbt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    byte_next = data_byte;
                    last_next = end_of_doc;
                    pos_next  = byte_position_reg;
                    if (byte_position_reg < POS_W'(jbt_pkg::MAX_DOC_BYTES))
                        byte_position_next = byte_position_reg + POS_W'(1);
                end
            end
            jbt_pkg::S_DISPATCH:
            begin
                if (!err_reg)
                begin
                    if (pos_over)
                        err_next = 1'b1;
                    else
                    begin
                        unique case (scan_reg)
                            jbt_pkg::SM_PRIM:
                            begin
                                if (is_delim)
                                begin
                                    scan_next        = jbt_pkg::SM_NORMAL;
                                    alloc_kind_next  = jbt_pkg::TK_PRIM;
                                    alloc_first_next = pending_reg;
                                    alloc_last_next  = pos_reg;
                                    alloc_nx_next    = jbt_pkg::NX_DISPATCH;
                                end
                                else if (cls == jbt_pkg::CL_BAD)
                                    err_next = 1'b1;
                            end
                            jbt_pkg::SM_STRING:
                            begin
                                if (cls == jbt_pkg::CL_QUOTE)
                                begin
                                    scan_next        = jbt_pkg::SM_NORMAL;
                                    alloc_kind_next  = jbt_pkg::TK_STRING;
                                    alloc_first_next = pending_reg;
                                    alloc_last_next  = pos_reg;
                                    alloc_nx_next    = jbt_pkg::NX_DONE;
                                end
                                else if (cls == jbt_pkg::CL_BACKSLASH)
                                    scan_next = jbt_pkg::SM_ESCAPE;
                            end
                            jbt_pkg::SM_ESCAPE:
                            begin
                                scan_next = jbt_pkg::SM_STRING;
                            end
                            jbt_pkg::SM_NORMAL:
                            begin
                                unique case (cls)
                                    jbt_pkg::CL_OPEN_OBJ,
                                    jbt_pkg::CL_OPEN_ARR:
                                    begin
                                        alloc_kind_next  = (cls == jbt_pkg::CL_OPEN_OBJ) ?
                                                           jbt_pkg::TK_OBJECT :
                                                           jbt_pkg::TK_ARRAY;
                                        alloc_first_next = pos_reg;
                                        alloc_last_next  = '0;
                                        alloc_nx_next    = jbt_pkg::NX_OPEN;
                                    end
                                    jbt_pkg::CL_CLOSE_OBJ,
                                    jbt_pkg::CL_CLOSE_ARR:
                                    begin
                                        if (!has_open)
                                            err_next = 1'b1;
                                    end
                                    jbt_pkg::CL_QUOTE:
                                    begin
                                        scan_next    = jbt_pkg::SM_STRING;
                                        pending_next = pos_reg + POS_W'(1);
                                    end
                                    jbt_pkg::CL_SEP:
                                    begin
                                        scan_next = scan_reg;
                                    end
                                    jbt_pkg::CL_BAD:
                                    begin
                                        err_next = 1'b1;
                                    end
                                    default:
                                    begin
                                        scan_next    = jbt_pkg::SM_PRIM;
                                        pending_next = pos_reg;
                                    end
                                endcase
                            end
                        endcase
                    end
                end
            end
            jbt_pkg::S_ALLOC:
            begin
                if (table_full)
                    err_next = 1'b1;
                else
                begin
                    ram_req.en          = 1'b1;
                    ram_req.we          = 1'b1;
                    ram_req.addr        = tokens_used_reg[IDX_W-1:0];
                    ram_req.wdata.kind  = alloc_kind_reg;
                    ram_req.wdata.first = alloc_first_reg;
                    ram_req.wdata.last  = alloc_last_reg;
                    ram_req.wdata.kids  = '0;
                    ram_req.wdata.up    = open_reg;
                    tokens_used_next    = tokens_used_reg + CNT_W'(1);
                end
            end
            jbt_pkg::S_BUMP_RD,
            jbt_pkg::S_CLOSE_RD:
            begin
                ram_req.en   = 1'b1;
                ram_req.addr = open_reg[IDX_W-1:0];
            end
            jbt_pkg::S_BUMP_WR:
            begin
                ram_req.en         = 1'b1;
                ram_req.we         = 1'b1;
                ram_req.addr       = open_reg[IDX_W-1:0];
                ram_req.wdata      = ram_rdata;
                ram_req.wdata.kids = ram_rdata.kids + jbt_pkg::KIDS_W'(1);
            end
            jbt_pkg::S_ALLOC_DONE:
            begin
                if (alloc_nx_reg == jbt_pkg::NX_OPEN)
                    open_next = tokens_used_reg - CNT_W'(1);
            end
            jbt_pkg::S_CLOSE_WR:
            begin
                if (ram_rdata.kind != want_kind)
                    err_next = 1'b1;
                else
                begin
                    ram_req.en         = 1'b1;
                    ram_req.we         = 1'b1;
                    ram_req.addr       = open_reg[IDX_W-1:0];
                    ram_req.wdata      = ram_rdata;
                    ram_req.wdata.last = pos_reg + POS_W'(1);
                    open_next          = ram_rdata.up;
                end
            end
            jbt_pkg::S_END_CHECK:
            begin
                if (!err_reg)
                begin
                    if (scan_reg == jbt_pkg::SM_PRIM)
                    begin
                        scan_next        = jbt_pkg::SM_NORMAL;
                        alloc_kind_next  = jbt_pkg::TK_PRIM;
                        alloc_first_next = pending_reg;
                        alloc_last_next  = byte_position_reg;
                        alloc_nx_next    = jbt_pkg::NX_END;
                    end
                    else if (scan_reg != jbt_pkg::SM_NORMAL || has_open)
                        err_next = 1'b1;
                end
            end
            jbt_pkg::S_END_DECIDE:
            begin
                emit_idx_next = '0;
            end
            jbt_pkg::S_EMIT_RD:
            begin
                ram_req.en   = 1'b1;
                ram_req.addr = emit_idx_reg[IDX_W-1:0];
            end
            jbt_pkg::S_EMIT_OUT:
            begin
                result_strobe = 1'b1;
                is_last       = emit_last;
                token_valid   = 1'b1;
                token_type    = ram_rdata.kind;
                start_pos     = ram_rdata.first;
                end_pos       = ram_rdata.last;
                child_count   = ram_rdata.kids;
                parent_index  = $signed(ram_rdata.up);
                token_count   = tokens_used_reg;
                emit_idx_next = emit_idx_reg + CNT_W'(1);
                run_clear     = emit_last;
            end
            jbt_pkg::S_RESULT_ONE:
            begin
                result_strobe = 1'b1;
                is_error      = err_reg;
                is_last       = 1'b1;
                run_clear     = 1'b1;
            end
            default:
            begin
                run_clear = 1'b0;
            end
        endcase

        // end of run: back to the reset state
        if (run_clear)
        begin
            scan_next          = jbt_pkg::SM_NORMAL;
            byte_position_next = '0;
            pending_next       = '0;
            open_next          = jbt_pkg::NO_TOKEN;
            tokens_used_next   = '0;
            emit_idx_next      = '0;
            err_next           = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= jbt_pkg::S_IDLE;
            scan_reg          <= jbt_pkg::SM_NORMAL;
            last_reg          <= 1'b0;
            byte_position_reg <= '0;
            pending_reg       <= '0;
            open_reg          <= jbt_pkg::NO_TOKEN;
            tokens_used_reg   <= '0;
            emit_idx_reg      <= '0;
            err_reg           <= 1'b0;
            alloc_nx_reg      <= jbt_pkg::NX_DONE;
        end
        else
        begin
            state_reg         <= state_next;
            scan_reg          <= scan_next;
            last_reg          <= last_next;
            byte_position_reg <= byte_position_next;
            pending_reg       <= pending_next;
            open_reg          <= open_next;
            tokens_used_reg   <= tokens_used_next;
            emit_idx_reg      <= emit_idx_next;
            err_reg           <= err_next;
            alloc_nx_reg      <= alloc_nx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        pos_reg         <= pos_next;
        alloc_kind_reg  <= alloc_kind_next;
        alloc_first_reg <= alloc_first_next;
        alloc_last_reg  <= alloc_last_next;
    end

    a_tokens_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        tokens_used_reg <= CNT_W'(jbt_pkg::MAX_TOKENS))
        else $error("token count beyond table size");

    a_no_write_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.en && ram_req.we) |-> !err_reg)
        else $error("token memory written after error");

    a_open_is_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg != jbt_pkg::NO_TOKEN) |-> (open_reg < tokens_used_reg))
        else $error("open container points past allocated tokens");

    a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && is_last) |=>
            (state_reg == jbt_pkg::S_IDLE && tokens_used_reg == '0 &&
             open_reg == jbt_pkg::NO_TOKEN && !err_reg))
        else $error("state not cleared after final result");

endmodule

`default_nettype wire

FILE: hdl/json_byte_tokenizer.sv
// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// request   | start & !busy                  | data_byte, end_of_doc
// result    | result_strobe (one cycle each) | is_error, is_last, token_valid, token_type,
//           |                                | start_pos, end_pos, child_count,
//           |                                | parent_index, token_count
//
// a request is dispatched, then may allocate or close a token: single-port token memory,
// each token allocation writes the entry and, if a container is open, read-modify-writes
// the parent child count, a close reads then writes the container entry; busy is high
// until the request is done; the final byte adds end checks, then one result, or one
// result per token (memory read then output); state then returns to its reset values
// rst_n clears all control state; token memory is not cleared, only written entries
// are read; results cannot be stalled by the receiver
`default_nettype none

module json_byte_tokenizer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          end_of_doc,
    output logic                               result_strobe,
    output logic                               is_error,
    output logic                               is_last,
    output logic                               token_valid,
    output logic [1:0]                         token_type,
    output logic [jbt_pkg::POS_W-1:0]          start_pos,
    output logic [jbt_pkg::POS_W-1:0]          end_pos,
    output logic [jbt_pkg::KIDS_W-1:0]         child_count,
    output logic signed [jbt_pkg::CNT_W-1:0]   parent_index,
    output logic [jbt_pkg::CNT_W-1:0]          token_count
);

    jbt_pkg::ram_req_t    ram_req;
    jbt_pkg::tok_entry_t  ram_rdata;

    jbt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .data_byte     (data_byte),
        .end_of_doc    (end_of_doc),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .result_strobe (result_strobe),
        .is_error      (is_error),
        .is_last       (is_last),
        .token_valid   (token_valid),
        .token_type    (token_type),
        .start_pos     (start_pos),
        .end_pos       (end_pos),
        .child_count   (child_count),
        .parent_index  (parent_index),
        .token_count   (token_count)
    );

    jbt_token_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

FILE: bench/jbt_token_checker.sv
module jbt_token_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [7:0]                        data_byte,
    input  logic                              end_of_doc,
    input  logic                              result_strobe,
    input  logic                              is_error,
    input  logic                              is_last,
    input  logic                              token_valid,
    input  logic [1:0]                        token_type,
    input  logic [jbt_pkg::POS_W-1:0]         start_pos,
    input  logic [jbt_pkg::POS_W-1:0]         end_pos,
    input  logic [jbt_pkg::KIDS_W-1:0]        child_count,
    input  logic signed [jbt_pkg::CNT_W-1:0]  parent_index,
    input  logic [jbt_pkg::CNT_W-1:0]         token_count,
    output int                                fail_count,
    output int                                pending_count
);

    typedef struct packed {
        logic                       err_flag;
        logic                       last_flag;
        logic                       valid_flag;
        logic [1:0]                 kind;
        logic [jbt_pkg::POS_W-1:0]  lo;
        logic [jbt_pkg::POS_W-1:0]  hi;
        logic [jbt_pkg::KIDS_W-1:0] kids;
        logic [jbt_pkg::CNT_W-1:0]  up;
        logic [jbt_pkg::CNT_W-1:0]  count;
    } token_row_t;

    jbt_pkg::tok_entry_t        table_mem [0:jbt_pkg::MAX_TOKENS-1];
    logic [jbt_pkg::CNT_W-1:0]  open_idx;
    logic [jbt_pkg::CNT_W-1:0]  used_cnt;
    int                         byte_pos;
    jbt_pkg::scan_mode_t        mode;
    logic [jbt_pkg::POS_W-1:0]  pend_start;
    logic                       doc_bad;
    token_row_t                 rows_due [$];
    token_row_t                 head_row;

    function automatic void reset_scan();
        open_idx   = jbt_pkg::NO_TOKEN;
        used_cnt   = '0;
        byte_pos   = 0;
        mode       = jbt_pkg::SM_NORMAL;
        pend_start = '0;
        doc_bad    = 1'b0;
    endfunction

    function automatic logic [jbt_pkg::CNT_W-1:0] alloc_token(jbt_pkg::tok_kind_t kind,
                                                              logic [jbt_pkg::POS_W-1:0] lo,
                                                              logic [jbt_pkg::POS_W-1:0] hi);
        logic [jbt_pkg::CNT_W-1:0] k;
        if (used_cnt >= jbt_pkg::MAX_TOKENS)
        begin
            doc_bad = 1'b1;
            return jbt_pkg::NO_TOKEN;
        end
        k = used_cnt;
        used_cnt = used_cnt + 1'b1;
        table_mem[k[jbt_pkg::IDX_W-1:0]].kind  = kind;
        table_mem[k[jbt_pkg::IDX_W-1:0]].first = lo;
        table_mem[k[jbt_pkg::IDX_W-1:0]].last  = hi;
        table_mem[k[jbt_pkg::IDX_W-1:0]].kids  = '0;
        table_mem[k[jbt_pkg::IDX_W-1:0]].up    = open_idx;
        if (open_idx != jbt_pkg::NO_TOKEN && open_idx < jbt_pkg::MAX_TOKENS)
            table_mem[open_idx[jbt_pkg::IDX_W-1:0]].kids =
                table_mem[open_idx[jbt_pkg::IDX_W-1:0]].kids + 1'b1;
        return k;
    endfunction

    function automatic bit is_separator(logic [7:0] c);
        return c == jbt_pkg::CH_SPACE || c == jbt_pkg::CH_TAB || c == jbt_pkg::CH_CR ||
               c == jbt_pkg::CH_LF || c == jbt_pkg::CH_COMMA || c == jbt_pkg::CH_COLON;
    endfunction

    function automatic void scan_normal(logic [7:0] c, logic [jbt_pkg::POS_W-1:0] pos);
        logic [jbt_pkg::CNT_W-1:0] k;
        jbt_pkg::tok_kind_t        want;
        if (c == jbt_pkg::CH_LBRACE || c == jbt_pkg::CH_LBRACKET)
        begin
            k = alloc_token(c == jbt_pkg::CH_LBRACE ? jbt_pkg::TK_OBJECT : jbt_pkg::TK_ARRAY,
                            pos, '0);
            if (k != jbt_pkg::NO_TOKEN)
                open_idx = k;
        end
        else if (c == jbt_pkg::CH_RBRACE || c == jbt_pkg::CH_RBRACKET)
        begin
            want = (c == jbt_pkg::CH_RBRACE) ? jbt_pkg::TK_OBJECT : jbt_pkg::TK_ARRAY;
            if (open_idx == jbt_pkg::NO_TOKEN || open_idx >= jbt_pkg::MAX_TOKENS ||
                table_mem[open_idx[jbt_pkg::IDX_W-1:0]].kind != want)
                doc_bad = 1'b1;
            else
            begin
                table_mem[open_idx[jbt_pkg::IDX_W-1:0]].last = pos + 1'b1;
                open_idx = table_mem[open_idx[jbt_pkg::IDX_W-1:0]].up;
            end
        end
        else if (c == jbt_pkg::CH_QUOTE)
        begin
            mode = jbt_pkg::SM_STRING;
            pend_start = pos + 1'b1;
        end
        else if (is_separator(c))
        begin
        end
        else if (c < jbt_pkg::PRINT_LO || c >= jbt_pkg::PRINT_HI)
            doc_bad = 1'b1;
        else
        begin
            mode = jbt_pkg::SM_PRIM;
            pend_start = pos;
        end
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [jbt_pkg::POS_W-1:0] pos;
        pos = byte_pos[jbt_pkg::POS_W-1:0];
        if (!doc_bad)
        begin
            if (byte_pos >= jbt_pkg::MAX_DOC_BYTES)
                doc_bad = 1'b1;
            else
            begin
                case (mode)
                    jbt_pkg::SM_PRIM:
                    begin
                        if (is_separator(c) || c == jbt_pkg::CH_RBRACKET ||
                            c == jbt_pkg::CH_RBRACE)
                        begin
                            mode = jbt_pkg::SM_NORMAL;
                            if (alloc_token(jbt_pkg::TK_PRIM, pend_start, pos) !=
                                jbt_pkg::NO_TOKEN)
                                scan_normal(c, pos);
                        end
                        else if (c < jbt_pkg::PRINT_LO || c >= jbt_pkg::PRINT_HI)
                            doc_bad = 1'b1;
                    end
                    jbt_pkg::SM_STRING:
                    begin
                        if (c == jbt_pkg::CH_QUOTE)
                        begin
                            mode = jbt_pkg::SM_NORMAL;
                            void'(alloc_token(jbt_pkg::TK_STRING, pend_start, pos));
                        end
                        else if (c == jbt_pkg::CH_BACKSLASH)
                            mode = jbt_pkg::SM_ESCAPE;
                    end
                    jbt_pkg::SM_ESCAPE:
                        mode = jbt_pkg::SM_STRING;
                    default:
                        scan_normal(c, pos);
                endcase
            end
        end
        if (byte_pos < jbt_pkg::MAX_DOC_BYTES)
            byte_pos = byte_pos + 1;
    endfunction

    function automatic void close_doc();
        token_row_t row;
        if (!doc_bad)
        begin
            if (mode == jbt_pkg::SM_PRIM)
            begin
                mode = jbt_pkg::SM_NORMAL;
                void'(alloc_token(jbt_pkg::TK_PRIM, pend_start,
                                  byte_pos[jbt_pkg::POS_W-1:0]));
            end
            else if (mode != jbt_pkg::SM_NORMAL)
                doc_bad = 1'b1;
            if (open_idx != jbt_pkg::NO_TOKEN)
                doc_bad = 1'b1;
        end
        if (doc_bad || used_cnt == 0)
        begin
            row = '0;
            row.err_flag = doc_bad;
            row.last_flag = 1'b1;
            rows_due.push_back(row);
        end
        else
        begin
            for (int i = 0; i < used_cnt; i++)
            begin
                row.err_flag   = 1'b0;
                row.last_flag  = (i + 1 == used_cnt);
                row.valid_flag = 1'b1;
                row.kind       = table_mem[i[jbt_pkg::IDX_W-1:0]].kind;
                row.lo         = table_mem[i[jbt_pkg::IDX_W-1:0]].first;
                row.hi         = table_mem[i[jbt_pkg::IDX_W-1:0]].last;
                row.kids       = table_mem[i[jbt_pkg::IDX_W-1:0]].kids;
                row.up         = table_mem[i[jbt_pkg::IDX_W-1:0]].up;
                row.count      = used_cnt;
                rows_due.push_back(row);
            end
        end
        reset_scan();
    endfunction

    function automatic void check_field(string name, logic [jbt_pkg::POS_W-1:0] want,
                                        logic [jbt_pkg::POS_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // results of a document never share an edge with its own final request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_scan();
            rows_due.delete();
            pending_count = 0;
            fail_count = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (rows_due.size() == 0)
                begin
                    $error("result strobe with no token row outstanding");
                    fail_count++;
                end
                else
                begin
                    head_row = rows_due.pop_front();
                    check_field("is_error", jbt_pkg::POS_W'(head_row.err_flag),
                                jbt_pkg::POS_W'(is_error));
                    check_field("is_last", jbt_pkg::POS_W'(head_row.last_flag),
                                jbt_pkg::POS_W'(is_last));
                    check_field("token_valid", jbt_pkg::POS_W'(head_row.valid_flag),
                                jbt_pkg::POS_W'(token_valid));
                    check_field("token_type", jbt_pkg::POS_W'(head_row.kind),
                                jbt_pkg::POS_W'(token_type));
                    check_field("start_pos", head_row.lo, start_pos);
                    check_field("end_pos", head_row.hi, end_pos);
                    check_field("child_count", jbt_pkg::POS_W'(head_row.kids),
                                jbt_pkg::POS_W'(child_count));
                    check_field("parent_index", jbt_pkg::POS_W'(head_row.up),
                                jbt_pkg::POS_W'($unsigned(parent_index)));
                    check_field("token_count", jbt_pkg::POS_W'(head_row.count),
                                jbt_pkg::POS_W'(token_count));
                end
            end
            if (start && !busy)
            begin
                scan_byte(data_byte);
                if (end_of_doc)
                    close_doc();
            end
            pending_count = rows_due.size();
        end
    end

endmodule

FILE: bench/testbench.sv
module testbench;

    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 30;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic [7:0]                         data_byte = 8'h00;
    logic                               end_of_doc = 1'b0;
    logic                               busy;
    logic                               result_strobe;
    logic                               is_error;
    logic                               is_last;
    logic                               token_valid;
    logic [1:0]                         token_type;
    logic [jbt_pkg::POS_W-1:0]          start_pos;
    logic [jbt_pkg::POS_W-1:0]          end_pos;
    logic [jbt_pkg::KIDS_W-1:0]         child_count;
    logic signed [jbt_pkg::CNT_W-1:0]   parent_index;
    logic [jbt_pkg::CNT_W-1:0]          token_count;
    int                                 fail_count;
    int                                 pending_count;

    int                                 quiet_cycles = 0;
    int                                 burst_left = 0;
    logic [7:0]                         doc [$];
    string                              prim_lead = "-0123456789tfn";

    always #6 clk = ~clk;

    json_byte_tokenizer DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .data_byte(data_byte), .end_of_doc(end_of_doc),
        .result_strobe(result_strobe), .is_error(is_error), .is_last(is_last),
        .token_valid(token_valid), .token_type(token_type), .start_pos(start_pos),
        .end_pos(end_pos), .child_count(child_count), .parent_index(parent_index),
        .token_count(token_count)
    );

    jbt_token_checker token_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .data_byte(data_byte), .end_of_doc(end_of_doc),
        .result_strobe(result_strobe), .is_error(is_error), .is_last(is_last),
        .token_valid(token_valid), .token_type(token_type), .start_pos(start_pos),
        .end_pos(end_pos), .child_count(child_count), .parent_index(parent_index),
        .token_count(token_count), .fail_count(fail_count), .pending_count(pending_count)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("json_byte_tokenizer: mismatch");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
                data_byte <= 8'($urandom_range(0, 255));
                end_of_doc <= 1'($urandom_range(0, 1));
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        data_byte <= b;
        end_of_doc <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic feed_doc();
        foreach (doc[i])
            send_byte(doc[i], i == doc.size() - 1);
    endtask

    function automatic void load_text(string s);
        doc.delete();
        for (int i = 0; i < s.len(); i++)
            doc.push_back(s[i]);
    endfunction

    function automatic void add_ws();
        case ($urandom_range(0, 7))
            0: doc.push_back(jbt_pkg::CH_SPACE);
            1: doc.push_back(jbt_pkg::CH_TAB);
            2: doc.push_back(jbt_pkg::CH_CR);
            3: doc.push_back(jbt_pkg::CH_LF);
            default: ;
        endcase
    endfunction

    function automatic void add_string();
        logic [7:0] c;
        doc.push_back(jbt_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                doc.push_back(jbt_pkg::CH_BACKSLASH);
                doc.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                c = 8'($urandom_range(0, 255));
                if (c == jbt_pkg::CH_QUOTE || c == jbt_pkg::CH_BACKSLASH)
                    c = "s";
                doc.push_back(c);
            end
        end
        doc.push_back(jbt_pkg::CH_QUOTE);
    endfunction

    function automatic void add_prim();
        logic [7:0] c;
        doc.push_back(prim_lead[$urandom_range(0, prim_lead.len() - 1)]);
        repeat ($urandom_range(0, 3))
        begin
            c = 8'($urandom_range(33, 126));
            if (c == jbt_pkg::CH_COMMA || c == jbt_pkg::CH_COLON ||
                c == jbt_pkg::CH_RBRACE || c == jbt_pkg::CH_RBRACKET)
                c = "0";
            doc.push_back(c);
        end
    endfunction

    function automatic void add_value(int depth);
        bit obj;
        int n;
        if (depth >= 3 || doc.size() > 40 || $urandom_range(0, 2) != 0)
        begin
            if ($urandom_range(0, 1))
                add_string();
            else
                add_prim();
        end
        else
        begin
            obj = 1'($urandom_range(0, 1));
            doc.push_back(obj ? jbt_pkg::CH_LBRACE : jbt_pkg::CH_LBRACKET);
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
            begin
                add_ws();
                if (i > 0)
                begin
                    doc.push_back(jbt_pkg::CH_COMMA);
                    add_ws();
                end
                if (obj)
                begin
                    add_string();
                    add_ws();
                    doc.push_back(jbt_pkg::CH_COLON);
                    add_ws();
                end
                add_value(depth + 1);
            end
            add_ws();
            doc.push_back(obj ? jbt_pkg::CH_RBRACE : jbt_pkg::CH_RBRACKET);
        end
    endfunction

    // returns 1 when the document was left well formed
    function automatic bit make_doc();
        doc.delete();
        add_ws();
        add_value(0);
        if ($urandom_range(0, 3) == 0)
        begin
            doc.push_back(jbt_pkg::CH_SPACE);
            add_value(0);
        end
        add_ws();
        if ($urandom_range(0, 3) != 0)
            return 1'b1;
        case ($urandom_range(0, 3))
            0: doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
            1: repeat ($urandom_range(1, doc.size() - 1)) void'(doc.pop_back());
            2: doc.push_back($urandom_range(0, 1) ? jbt_pkg::CH_RBRACE : jbt_pkg::CH_RBRACKET);
            default:
            begin
                doc.delete();
                repeat ($urandom_range(1, 8))
                    doc.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        return 1'b0;
    endfunction

    initial
    begin
        int sent;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_text("[1,\"a\\\"b\"]");
        feed_doc();
        load_text("{\"k\": -~}");
        feed_doc();
        load_text("\t\r\n ,:");
        feed_doc();
        load_text("]");
        feed_doc();
        load_text("[}");
        feed_doc();
        load_text("\"ab");
        feed_doc();
        load_text("\"\\");
        feed_doc();
        load_text("[");
        feed_doc();
        load_text("x");
        doc.push_back(8'h7F);
        feed_doc();
        doc = {8'hFF};
        feed_doc();
        load_text("12");
        feed_doc();

        // token table filled exactly, then one token too many
        doc = {jbt_pkg::CH_LBRACKET};
        for (int i = 0; i < jbt_pkg::MAX_TOKENS - 1; i++)
        begin
            doc.push_back("1");
            if (i < jbt_pkg::MAX_TOKENS - 2)
                doc.push_back(jbt_pkg::CH_COMMA);
        end
        doc.push_back(jbt_pkg::CH_RBRACKET);
        feed_doc();
        doc.delete();
        repeat (jbt_pkg::MAX_TOKENS + 1)
            doc.push_back(jbt_pkg::CH_LBRACKET);
        feed_doc();

        sent = 0;
        while (sent < 80)
        begin
            void'(make_doc());
            sent += doc.size();
            feed_doc();
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("json_byte_tokenizer: match");
        else
            $display("json_byte_tokenizer: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/jbt_pkg.sv
hdl/jbt_byte_class.sv
hdl/jbt_token_ram.sv
hdl/jbt_ctrl.sv
hdl/json_byte_tokenizer.sv
bench/jbt_token_checker.sv
bench/testbench.sv
